>>> src/pst_pkg.sv
// Shared types and constants for the per-type sensor statistics block.
// Used by pst_divider and per_type_sensor_stats; depends on nothing else.
package pst_pkg;

  localparam logic [3:0] TYPE_LOW  = 4'd1;
  localparam logic [3:0] TYPE_HIGH = 4'd7;
  localparam int NUM_SLOTS = 8;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);

  localparam int SAMPLE_W = 16;
  localparam int SUM_W    = 48;
  localparam int COUNT_W  = 32;
  localparam int TIME_W   = 32;
  localparam int DIV_CNT_W = $clog2(SUM_W);

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic ACT_SUBMIT = 1'b0;
  localparam logic ACT_QUERY  = 1'b1;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_BAD_TYPE = 1'b1;

  typedef struct packed {
    logic                       action;
    logic [3:0]                 sensor_type;
    logic signed [SAMPLE_W-1:0] sample_value;
    logic [TIME_W-1:0]          timestamp;
  } req_t;

  typedef struct packed {
    logic                       status;
    logic signed [SAMPLE_W-1:0] latest_value;
    logic [COUNT_W-1:0]         sample_count;
    logic signed [SAMPLE_W-1:0] average_value;
    logic [TIME_W-1:0]          latest_time;
  } rsp_t;

endpackage

>>> src/pst_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Divides a SUM_W-bit dividend by a COUNT_W-bit divisor; uses pst_pkg.
module pst_divider (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [pst_pkg::SUM_W-1:0]      dividend,
  input  logic [pst_pkg::COUNT_W-1:0]    divisor,
  output logic                           busy,
  output logic                           done,
  output logic [pst_pkg::SUM_W-1:0]      quotient
);

  logic [pst_pkg::COUNT_W-1:0]   rem;
  logic [pst_pkg::COUNT_W-1:0]   dvs;
  logic [pst_pkg::SUM_W-1:0]     dq;
  logic [pst_pkg::DIV_CNT_W-1:0] cnt;
  logic [pst_pkg::COUNT_W:0]     shifted;
  logic [pst_pkg::COUNT_W:0]     diff;
  logic                          fits;

  // Bring down the next dividend bit and try the subtract.
  assign shifted = {rem, dq[pst_pkg::SUM_W-1]};
  assign diff    = shifted - {1'b0, dvs};
  assign fits    = ~diff[pst_pkg::COUNT_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == pst_pkg::DIV_CNT_W'(pst_pkg::SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Hold the divisor for the whole division.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      dq  <= dividend;
    end else if (busy) begin
      rem <= fits ? diff[pst_pkg::COUNT_W-1:0] : shifted[pst_pkg::COUNT_W-1:0];
      dq  <= {dq[pst_pkg::SUM_W-2:0], fits};
    end
  end

  assign quotient = dq;

endmodule

>>> src/per_type_sensor_stats.sv
// Per-type sensor statistics: latest reading, count, running sum and average.
// Submits and invalid types answer in the cycle after acceptance; a query
// waits for the 48-step shared restoring divider and then for the output register.
// One word at a time: the request side stalls while a query divides.
// Synchronous reset clears all per-type totals and empties the output register.
// Uses pst_pkg and pst_divider.
module per_type_sensor_stats (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  pst_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output pst_pkg::rsp_t  rsp
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  state_t state, state_next;

  logic signed [pst_pkg::SAMPLE_W-1:0] last_reading  [pst_pkg::NUM_SLOTS];
  logic signed [pst_pkg::SUM_W-1:0]    reading_sum   [pst_pkg::NUM_SLOTS];
  logic [pst_pkg::COUNT_W-1:0]         reading_count [pst_pkg::NUM_SLOTS];
  logic [pst_pkg::TIME_W-1:0]          last_time     [pst_pkg::NUM_SLOTS];

  logic                          req_fire;
  logic                          out_free;
  logic                          type_ok;
  logic [pst_pkg::SLOT_W-1:0]    idx;
  logic signed [pst_pkg::SUM_W-1:0] sum_sel;
  logic [pst_pkg::SUM_W-1:0]     sum_mag;

  logic                          div_start;
  logic                          div_busy;
  logic                          div_done;
  logic [pst_pkg::SUM_W-1:0]     div_quot;

  // Query snapshot held while dividing.
  logic signed [pst_pkg::SAMPLE_W-1:0] q_latest;
  logic [pst_pkg::COUNT_W-1:0]         q_count;
  logic [pst_pkg::TIME_W-1:0]          q_time;
  logic                                q_neg;
  logic [pst_pkg::SAMPLE_W-1:0]        q_avg;
  logic [pst_pkg::SAMPLE_W-1:0]        avg_next;

  logic          rsp_load;
  pst_pkg::rsp_t rsp_next;

  assign out_free  = ~rsp_valid | ~rsp_stall;
  assign req_stall = (state != ST_IDLE) | ~out_free;
  assign req_fire  = req_valid & ~req_stall;

  assign type_ok = (req.sensor_type >= pst_pkg::TYPE_LOW) &&
                   (req.sensor_type <= pst_pkg::TYPE_HIGH) &&
                   (int'(req.sensor_type) < pst_pkg::NUM_SLOTS);
  assign idx     = req.sensor_type[pst_pkg::SLOT_W-1:0];
  assign sum_sel = reading_sum[idx];
  assign sum_mag = sum_sel[pst_pkg::SUM_W-1] ? pst_pkg::SUM_W'(-sum_sel)
                                               : pst_pkg::SUM_W'(sum_sel);

  assign div_start = req_fire && type_ok && (req.action == pst_pkg::ACT_QUERY);

  pst_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_mag),
    .divisor  (reading_count[idx]),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (div_start) state_next = ST_DIV;
      ST_DIV:  if (div_done) state_next = ST_HOLD;
      ST_HOLD: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Per-type store update on submit.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < pst_pkg::NUM_SLOTS; i++) begin
        last_reading[i]  <= '0;
        reading_sum[i]   <= '0;
        reading_count[i] <= '0;
        last_time[i]     <= '0;
      end
    end else if (req_fire && type_ok && (req.action == pst_pkg::ACT_SUBMIT)) begin
      last_reading[idx] <= req.sample_value;
      last_time[idx]    <= req.timestamp;
      if (reading_count[idx] != pst_pkg::COUNT_MAX) begin
        reading_sum[idx]   <= reading_sum[idx] + pst_pkg::SUM_W'(req.sample_value);
        reading_count[idx] <= reading_count[idx] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      q_latest <= last_reading[idx];
      q_count  <= reading_count[idx];
      q_time   <= last_time[idx];
      q_neg    <= sum_sel[pst_pkg::SUM_W-1];
    end
    if (div_done) begin
      q_avg <= avg_next;
    end
  end

  // Apply the sign of the sum; an empty count averages to zero.
  always_comb begin
    if (q_count == '0) begin
      avg_next = '0;
    end else if (q_neg) begin
      avg_next = -div_quot[pst_pkg::SAMPLE_W-1:0];
    end else begin
      avg_next = div_quot[pst_pkg::SAMPLE_W-1:0];
    end
  end

  always_comb begin
    rsp_next = '0;
    rsp_load = 1'b0;
    if (state == ST_HOLD) begin
      rsp_load               = out_free;
      rsp_next.status        = pst_pkg::STATUS_OK;
      rsp_next.latest_value  = q_latest;
      rsp_next.sample_count  = q_count;
      rsp_next.average_value = q_avg;
      rsp_next.latest_time   = q_time;
    end else if (req_fire && !div_start) begin
      rsp_load        = 1'b1;
      rsp_next.status = type_ok ? pst_pkg::STATUS_OK : pst_pkg::STATUS_BAD_TYPE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    div_busy |-> req_stall)
    else $error("request accepted while divider busy");

  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == pst_pkg::STATUS_BAD_TYPE) |->
      (rsp.sample_count == '0 && rsp.latest_time == '0 && rsp.average_value == '0))
    else $error("error word carries nonzero fields");

  assert property (@(posedge clk) disable iff (rst)
    (req_fire && type_ok && req.action == pst_pkg::ACT_SUBMIT &&
     reading_count[idx] != pst_pkg::COUNT_MAX) |=>
      (reading_count[$past(idx)] == $past(reading_count[idx]) + 1'b1))
    else $error("count did not advance on submit");

  assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("divider finished outside a query");

endmodule

>>> verif/per_type_sensor_stats_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for per_type_sensor_stats: directed and random submits and queries.
// Predicts each response word from its own copy of the per-type totals. Uses pst_pkg and per_type_sensor_stats.
module per_type_sensor_stats_tb;

  logic           clk = 1'b0;
  logic           rst;
  logic           req_valid;
  logic           req_stall;
  pst_pkg::req_t  req;
  logic           rsp_valid;
  logic           rsp_stall;
  pst_pkg::rsp_t  rsp;

  // Predicted per-type totals
  logic signed [pst_pkg::SAMPLE_W-1:0] stat_latest [pst_pkg::NUM_SLOTS];
  longint                              stat_sum    [pst_pkg::NUM_SLOTS];
  logic [pst_pkg::COUNT_W-1:0]         stat_count  [pst_pkg::NUM_SLOTS];
  logic [pst_pkg::TIME_W-1:0]          stat_time   [pst_pkg::NUM_SLOTS];

  pst_pkg::rsp_t expected_stats_q[$];
  pst_pkg::rsp_t want_rsp;
  int   error_count = 0;
  bit   no_idle = 1'b0;

  per_type_sensor_stats DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #1 clk = ~clk;

  function automatic pst_pkg::req_t make_req(input logic act, input logic [3:0] kind,
                                    input logic signed [pst_pkg::SAMPLE_W-1:0] value,
                                    input logic [pst_pkg::TIME_W-1:0] stamp);
    pst_pkg::req_t word;
    word.action       = act;
    word.sensor_type  = kind;
    word.sample_value = value;
    word.timestamp    = stamp;
    return word;
  endfunction

  // Apply one request to the predicted totals and return the response it earns.
  function automatic pst_pkg::rsp_t predict_stats(input pst_pkg::req_t word);
    pst_pkg::rsp_t res;
    int unsigned   slot;
    longint        quot;
    res = '0;
    if (word.sensor_type < pst_pkg::TYPE_LOW || word.sensor_type > pst_pkg::TYPE_HIGH ||
        int'(word.sensor_type) >= pst_pkg::NUM_SLOTS) begin
      res.status = pst_pkg::STATUS_BAD_TYPE;
      return res;
    end
    slot = int'(word.sensor_type);
    res.status = pst_pkg::STATUS_OK;
    if (word.action == pst_pkg::ACT_SUBMIT) begin
      stat_latest[slot] = word.sample_value;
      stat_time[slot]   = word.timestamp;
      // saturated count freezes sum and count
      if (stat_count[slot] != pst_pkg::COUNT_MAX) begin
        stat_sum[slot]   += longint'(word.sample_value);
        stat_count[slot] += 32'd1;
      end
    end else begin
      quot = 0;
      if (stat_count[slot] != 0)
        quot = stat_sum[slot] / longint'({32'd0, stat_count[slot]});
      res.latest_value  = stat_latest[slot];
      res.sample_count  = stat_count[slot];
      res.average_value = quot[15:0];
      res.latest_time   = stat_time[slot];
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Present one word, hold it until accepted, then record its expected response.
  task automatic send_word(input pst_pkg::req_t word);
    int gap;
    @(negedge clk);
    if (!no_idle && $urandom_range(99) < 7) begin
      gap = $urandom_range(1, 60);
      req_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req       = word;
    req_valid = 1'b1;
    do @(posedge clk); while (req_stall);
    expected_stats_q.push_back(predict_stats(word));
  endtask

  task automatic wait_all_answered();
    @(negedge clk);
    req_valid = 1'b0;
    while (expected_stats_q.size() != 0) @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (rst || no_idle)
      rsp_stall <= 1'b0;
    else
      rsp_stall <= ($urandom_range(99) < 7);
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_stats_q.size() == 0) begin
        report_mismatch("unexpected word", rsp[63:0], '0);
      end else begin
        want_rsp = expected_stats_q.pop_front();
        if (rsp.status !== want_rsp.status)
          report_mismatch("status", 64'(rsp.status), 64'(want_rsp.status));
        if (rsp.latest_value !== want_rsp.latest_value)
          report_mismatch("latest_value", 64'(unsigned'(rsp.latest_value)),
                          64'(unsigned'(want_rsp.latest_value)));
        if (rsp.sample_count !== want_rsp.sample_count)
          report_mismatch("sample_count", 64'(rsp.sample_count),
                          64'(want_rsp.sample_count));
        if (rsp.average_value !== want_rsp.average_value)
          report_mismatch("average_value", 64'(unsigned'(rsp.average_value)),
                          64'(unsigned'(want_rsp.average_value)));
        if (rsp.latest_time !== want_rsp.latest_time)
          report_mismatch("latest_time", 64'(rsp.latest_time), 64'(want_rsp.latest_time));
      end
    end
  end

  task automatic test_queries_before_submit();
    send_word(make_req(pst_pkg::ACT_QUERY, pst_pkg::TYPE_LOW, 16'sh0000, 32'h0000_0000));
    send_word(make_req(pst_pkg::ACT_QUERY, pst_pkg::TYPE_HIGH, 16'sh7FFF, 32'hFFFF_FFFF));
  endtask

  task automatic test_invalid_types();
    send_word(make_req(pst_pkg::ACT_SUBMIT, 4'd0, 16'sh7FFF, 32'hFFFF_FFFF));
    send_word(make_req(pst_pkg::ACT_QUERY, 4'd0, 16'sh8000, 32'h0000_0000));
    send_word(make_req(pst_pkg::ACT_SUBMIT, 4'd8, 16'sh8000, 32'hFFFF_FFFF));
    send_word(make_req(pst_pkg::ACT_QUERY, 4'd15, 16'sh7FFF, 32'hFFFF_FFFF));
    send_word(make_req(pst_pkg::ACT_SUBMIT, 4'd15, 16'sh1234, 32'h5A5A_A5A5));
  endtask

  task automatic test_field_extremes();
    send_word(make_req(pst_pkg::ACT_SUBMIT, pst_pkg::TYPE_LOW, 16'sh7FFF, 32'hFFFF_FFFF));
    send_word(make_req(pst_pkg::ACT_SUBMIT, pst_pkg::TYPE_LOW, 16'sh7FFF, 32'h0000_0000));
    send_word(make_req(pst_pkg::ACT_QUERY, pst_pkg::TYPE_LOW, 16'sh0000, 32'hFFFF_FFFF));
    send_word(make_req(pst_pkg::ACT_SUBMIT, pst_pkg::TYPE_HIGH, 16'sh8000, 32'h0000_0000));
    send_word(make_req(pst_pkg::ACT_SUBMIT, pst_pkg::TYPE_HIGH, 16'sh8000, 32'hFFFF_FFFF));
    send_word(make_req(pst_pkg::ACT_QUERY, pst_pkg::TYPE_HIGH, 16'sh7FFF, 32'h0000_0000));
  endtask

  // Averages that must truncate toward zero on both signs.
  task automatic test_average_truncation();
    send_word(make_req(pst_pkg::ACT_SUBMIT, 4'd3, -16'sd3, 32'd10));
    send_word(make_req(pst_pkg::ACT_SUBMIT, 4'd3, -16'sd4, 32'd11));
    send_word(make_req(pst_pkg::ACT_QUERY, 4'd3, 16'sh0000, 32'd0));
    send_word(make_req(pst_pkg::ACT_SUBMIT, 4'd4, 16'sd5, 32'd20));
    send_word(make_req(pst_pkg::ACT_SUBMIT, 4'd4, 16'sd2, 32'd21));
    send_word(make_req(pst_pkg::ACT_QUERY, 4'd4, 16'sh0000, 32'd0));
    send_word(make_req(pst_pkg::ACT_SUBMIT, 4'd3, 16'sd1, 32'd12));
    send_word(make_req(pst_pkg::ACT_QUERY, 4'd3, 16'sh0000, 32'd0));
  endtask

  // Let the block go fully idle before the queries.
  task automatic test_query_after_quiet();
    send_word(make_req(pst_pkg::ACT_SUBMIT, 4'd5, 16'sd100, 32'd30));
    send_word(make_req(pst_pkg::ACT_SUBMIT, 4'd5, -16'sd301, 32'd31));
    wait_all_answered();
    send_word(make_req(pst_pkg::ACT_QUERY, 4'd5, 16'sh0000, 32'd0));
    send_word(make_req(pst_pkg::ACT_QUERY, 4'd6, 16'sh0000, 32'd0));
  endtask

  task automatic test_random_traffic(input int n_items);
    logic                                act;
    logic [3:0]                          kind;
    logic signed [pst_pkg::SAMPLE_W-1:0] value;
    int                                  pick;
    for (int k = 0; k < n_items; k++) begin
      no_idle = (k >= 600 && k < 900);
      if ($urandom_range(99) < 10)
        kind = ($urandom_range(1) == 0) ? 4'd0 : 4'($urandom_range(8, 15));
      else
        kind = 4'($urandom_range(pst_pkg::TYPE_LOW, pst_pkg::TYPE_HIGH));
      act  = ($urandom_range(99) < 55) ? pst_pkg::ACT_SUBMIT : pst_pkg::ACT_QUERY;
      pick = $urandom_range(9);
      case (pick)
        0:       value = 16'sh7FFF;
        1:       value = 16'sh8000;
        2, 3, 4: value = 16'($signed($urandom_range(40)) - 20);
        default: value = 16'($urandom);
      endcase
      send_word(make_req(act, kind, value, $urandom));
      if (k % 500 == 499) wait_all_answered();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    rsp_stall = 1'b0;
    for (int i = 0; i < pst_pkg::NUM_SLOTS; i++) begin
      stat_latest[i] = '0;
      stat_sum[i]    = 0;
      stat_count[i]  = '0;
      stat_time[i]   = '0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_queries_before_submit();
    test_invalid_types();
    test_field_extremes();
    test_average_truncation();
    test_query_after_quiet();
    test_random_traffic(1900);

    wait_all_answered();
    repeat (64) @(posedge clk);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TIMEOUT with %0d words outstanding", expected_stats_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> files.f
src/pst_pkg.sv
src/pst_divider.sv
src/per_type_sensor_stats.sv
verif/per_type_sensor_stats_tb.sv
